>>> rtl/trd_pkg.sv
`default_nettype none

package trd_pkg;

    // Sizes and limits
    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_HEIGHT    = 512;
    localparam int GROUP_PIXELS  = 16;
    localparam int WIDTH_W       = 10;
    localparam int POS_W         = 2 * WIDTH_W;
    localparam int NODE_W        = 7;
    localparam int GROUP_BITS_W  = 64;
    localparam int GROUP_SIZE_W  = 5;
    localparam int FIRST_W       = 18;
    localparam int OUT_DATA_W    = 88;

    // Tree byte coding
    localparam logic [6:0] RUN_BASE = 7'h10;

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_TREE  = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    // Register indexes
    localparam logic [1:0] CFG_ROOT   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIT_RD,
        ST_BIT_EV,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_END
    } state_t;

    // One finished pixel group
    typedef struct packed {
        logic [GROUP_BITS_W-1:0] bits;
        logic [GROUP_SIZE_W-1:0] size;
        logic [FIRST_W-1:0]      first;
        logic                    done;
        logic                    err;
    } group_t;

    // Status of the output stage
    typedef struct packed {
        logic can_push;
        logic out_free;
        logic hold_valid;
    } out_stat_t;

endpackage

`default_nettype wire

>>> rtl/trd_tree_mem.sv
`default_nettype none

module trd_tree_mem (
    input  wire        aclk,
    input  wire        we,
    input  wire  [7:0] waddr,
    input  wire  [7:0] wdata,
    input  wire        re,
    input  wire  [7:0] raddr,
    output logic [7:0] rdata
);

    logic [7:0] mem [256];

    // Write tree bytes
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/trd_line_store.sv
`default_nettype none

module trd_line_store #(
    parameter int DEPTH = trd_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire           aclk,
    input  wire           we,
    input  wire  [AW-1:0] waddr,
    input  wire  [3:0]    wdata,
    input  wire           re,
    input  wire  [AW-1:0] raddr,
    output logic [3:0]    rdata
);

    logic [3:0] mem [DEPTH];

    // Write output pixels of the current row
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read of the pixel one row above
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/trd_group_out.sv
`default_nettype none

module trd_group_out (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              push,
    input  trd_pkg::group_t                  push_grp,
    input  wire                              close,
    output trd_pkg::out_stat_t               stat,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // pixel_group[63:0], group_size[68:64], first_pixel[86:69], zero pad
    output logic [trd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // picture_done[0], zero_run_error[1]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    import trd_pkg::*;

    group_t hold_reg;
    logic   hold_valid_reg, hold_valid_next;
    group_t out_reg;
    logic   out_last_reg;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;
    logic   load_out;

    // A group waits in the hold stage until it is known whether another follows
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = hold_valid_reg && ((push && out_free) || (close && out_free));

    assign stat.can_push   = !hold_valid_reg || out_free;
    assign stat.out_free   = out_free;
    assign stat.hold_valid = hold_valid_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (push) begin
            hold_valid_next = 1'b1;
        end else if (load_out) begin
            hold_valid_next = 1'b0;
        end
        m_tvalid_next = (m_tvalid_reg && !m_tready) || load_out;
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload: move hold to output, capture a pushed group
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg      <= hold_reg;
            out_last_reg <= !push;
        end
        if (push) begin
            hold_reg <= push_grp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.first, out_reg.size, out_reg.bits};
    assign m_tuser  = {out_reg.err, out_reg.done};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/tree_rle_delta_image_decoder.sv
`default_nettype none

// Decoder for tree-coded, run-length 4-bit pictures with a row-to-row XOR.
// Input beats carry the kind in s_tuser: tree byte loads, picture starts
// and compressed data bytes. A data byte is walked one bit at a time
// through the code tree memory: a bit that lands on an inner node is
// handled in ST_BIT_EV alone, the first bit and each bit after a leaf
// pass through ST_BIT_RD and ST_BIT_EV, and every emitted pixel passes
// through ST_PIX_RD and ST_PIX_WR for the read and write of the line
// store; the output side can stall the decode, and s_tready is low while
// a byte is being decoded. Pixel groups of up to 16 leave on the m_ side,
// and m_tlast marks the last group of a byte. After reset the line store
// is cleared, one entry per cycle for all MAX_WIDTH entries, before the
// first item is taken; configuration writes are accepted at any time.
module tree_rle_delta_image_decoder #(
    parameter int MAX_WIDTH = trd_pkg::MAX_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input beats
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // table_index[7:0], table_value[15:8], data_byte[23:16]
    input  wire  [23:0]                      s_tdata,
    // action[1:0]
    input  wire  [1:0]                       s_tuser,
    // result beats
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // pixel_group[63:0], group_size[68:64], first_pixel[86:69], zero pad
    output logic [trd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // picture_done[0], zero_run_error[1]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    // configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [1:0]                       cfg_index,
    input  wire  [trd_pkg::WIDTH_W-1:0]      cfg_data
);

    import trd_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    state_t state_reg, state_next;

    logic [CW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]       root_reg;
    logic [WIDTH_W-1:0]      width_reg, height_reg;
    logic [NODE_W-1:0]       tree_pos_reg, tree_pos_next;
    logic [3:0]              last_lit_reg, last_lit_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CW-1:0]           col_reg, col_next;
    logic                    finished_reg, finished_next;
    logic [7:0]              data_reg, data_next;
    logic [2:0]              bit_idx_reg, bit_idx_next;
    logic [WIDTH_W-1:0]      w_reg, w_next;
    logic [POS_W-1:0]        total_reg, total_next;
    logic [6:0]              run_cnt_reg, run_cnt_next;
    logic                    run_err_reg, run_err_next;
    logic [GROUP_BITS_W-1:0] grp_bits_reg, grp_bits_next;
    logic [GROUP_SIZE_W-1:0] grp_cnt_reg, grp_cnt_next;
    logic [FIRST_W-1:0]      grp_first_reg, grp_first_next;
    logic                    grp_err_reg, grp_err_next;
    logic                    grp_done_reg, grp_done_next;

    logic                    in_fire, cfg_fire;
    logic [WIDTH_W-1:0]      eff_w, eff_h;
    logic [POS_W-1:0]        eff_total;
    logic                    at_end;
    logic                    last_bit;
    logic                    child;
    logic [6:0]              code;
    logic [POS_W-1:0]        pos_inc;
    logic                    end_hit;
    logic [CMPW-1:0]         col_inc;
    logic                    col_wrap;
    logic                    first_row;
    logic [3:0]              pix_val;
    logic                    pix_flush;
    logic                    pix_stall;
    group_t                  cur_grp, upd_grp;

    logic                    tree_we, tree_re;
    logic [7:0]              tree_waddr, tree_wdata, tree_raddr, tree_rdata;
    logic                    line_we, line_re;
    logic [CW-1:0]           line_waddr, line_raddr;
    logic [3:0]              line_wdata, line_rdata;
    logic                    push, close;
    group_t                  push_grp;
    out_stat_t               stat;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg   <= '0;
            width_reg  <= WIDTH_W'(320);
            height_reg <= WIDTH_W'(200);
        end else if (cfg_fire) begin
            priority case (cfg_index)
                CFG_ROOT:   root_reg   <= cfg_data[NODE_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated picture size
    always_comb begin
        eff_w     = (32'(width_reg) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : width_reg;
        eff_h     = (32'(height_reg) > MAX_HEIGHT) ? WIDTH_W'(MAX_HEIGHT) : height_reg;
        eff_total = POS_W'(eff_w) * POS_W'(eff_h);
    end

    // Shared decode conditions
    always_comb begin
        at_end    = pos_reg >= total_reg;
        last_bit  = (bit_idx_reg == 3'd0);
        child     = !tree_rdata[7];
        code      = tree_rdata[6:0];
        pos_inc   = pos_reg + POS_W'(1);
        end_hit   = pos_inc >= total_reg;
        col_inc   = CMPW'(col_reg) + CMPW'(1);
        col_wrap  = col_inc >= CMPW'(w_reg);
        first_row = pos_reg < POS_W'(w_reg);
        pix_val   = first_row ? last_lit_reg : (last_lit_reg ^ line_rdata);
        pix_flush = (grp_cnt_reg == GROUP_SIZE_W'(GROUP_PIXELS - 1)) || end_hit;
        pix_stall = pix_flush && !stat.can_push;
    end

    // Current and updated pixel group
    always_comb begin
        cur_grp.bits  = grp_bits_reg;
        cur_grp.size  = grp_cnt_reg;
        cur_grp.first = grp_first_reg;
        cur_grp.done  = grp_done_reg;
        cur_grp.err   = grp_err_reg;

        upd_grp = cur_grp;
        upd_grp.bits[{grp_cnt_reg[3:0], 2'b00} +: 4] = pix_val;
        upd_grp.size  = grp_cnt_reg + GROUP_SIZE_W'(1);
        upd_grp.first = (grp_cnt_reg == '0) ? pos_reg[FIRST_W-1:0] : grp_first_reg;
        upd_grp.done  = end_hit;
        upd_grp.err   = grp_err_reg || run_err_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CW'(MAX_WIDTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire && s_tuser == ACT_DATA) begin
                    state_next = ST_BIT_RD;
                end
            end
            ST_BIT_RD: begin
                state_next = (finished_reg || at_end) ? ST_END : ST_BIT_EV;
            end
            ST_BIT_EV: begin
                if (!child) begin
                    state_next = ST_PIX_RD;
                end else if (last_bit) begin
                    state_next = ST_END;
                end
            end
            ST_PIX_RD: begin
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                if (!pix_stall) begin
                    priority if (end_hit) begin
                        state_next = ST_END;
                    end else if (run_cnt_reg > 7'd1) begin
                        state_next = ST_PIX_RD;
                    end else if (last_bit) begin
                        state_next = ST_END;
                    end else begin
                        state_next = ST_BIT_RD;
                    end
                end
            end
            ST_END: begin
                if (grp_cnt_reg == '0) begin
                    if (!stat.hold_valid || stat.out_free) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        tree_pos_next  = tree_pos_reg;
        last_lit_next  = last_lit_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        finished_next  = finished_reg;
        data_next      = data_reg;
        bit_idx_next   = bit_idx_reg;
        w_next         = w_reg;
        total_next     = total_reg;
        run_cnt_next   = run_cnt_reg;
        run_err_next   = run_err_reg;
        grp_bits_next  = grp_bits_reg;
        grp_cnt_next   = grp_cnt_reg;
        grp_first_next = grp_first_reg;
        grp_err_next   = grp_err_reg;
        grp_done_next  = grp_done_reg;

        tree_we    = 1'b0;
        tree_waddr = s_tdata[7:0];
        tree_wdata = s_tdata[15:8];
        tree_re    = 1'b0;
        tree_raddr = {tree_pos_reg, !data_reg[bit_idx_reg]};
        line_we    = 1'b0;
        line_waddr = col_reg;
        line_wdata = pix_val;
        line_re    = 1'b0;
        line_raddr = col_reg;
        push       = 1'b0;
        push_grp   = cur_grp;
        close      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep the line store to zero
                line_we      = 1'b1;
                line_waddr   = clr_cnt_reg;
                line_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
            end
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (s_tuser)
                        ACT_TREE: begin
                            tree_we = 1'b1;
                        end
                        ACT_DATA: begin
                            data_next    = s_tdata[23:16];
                            bit_idx_next = 3'd7;
                            w_next       = eff_w;
                            total_next   = eff_total;
                        end
                        ACT_START: begin
                            tree_pos_next = root_reg;
                            last_lit_next = '0;
                            pos_next      = '0;
                            col_next      = '0;
                            finished_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BIT_RD: begin
                // Drop the byte once the picture is complete
                if (!finished_reg) begin
                    if (at_end) begin
                        finished_next = 1'b1;
                    end else begin
                        tree_re = 1'b1;
                    end
                end
            end
            ST_BIT_EV: begin
                if (child) begin
                    // Step to the child node and fetch for the next bit
                    tree_pos_next = tree_rdata[6:0];
                    if (!last_bit) begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                        tree_re      = 1'b1;
                        tree_raddr   = {tree_rdata[6:0], !data_reg[bit_idx_reg - 3'd1]};
                    end
                end else begin
                    // Leaf: restart the walk and set up the pixel run
                    tree_pos_next = root_reg;
                    if (code < RUN_BASE) begin
                        last_lit_next = code[3:0];
                        run_cnt_next  = 7'd1;
                        run_err_next  = 1'b0;
                    end else if (code == RUN_BASE) begin
                        run_cnt_next = 7'd1;
                        run_err_next = 1'b1;
                    end else begin
                        run_cnt_next = code - RUN_BASE;
                        run_err_next = 1'b0;
                    end
                end
            end
            ST_PIX_RD: begin
                line_re = 1'b1;
            end
            ST_PIX_WR: begin
                if (!pix_stall) begin
                    // Write the pixel back and advance the position
                    line_we      = 1'b1;
                    pos_next     = pos_inc;
                    col_next     = col_wrap ? '0 : CW'(col_inc);
                    run_cnt_next = run_cnt_reg - 7'd1;
                    if (end_hit) begin
                        finished_next = 1'b1;
                    end
                    if (pix_flush) begin
                        push           = 1'b1;
                        push_grp       = upd_grp;
                        grp_bits_next  = '0;
                        grp_cnt_next   = '0;
                        grp_err_next   = 1'b0;
                        grp_done_next  = 1'b0;
                    end else begin
                        grp_bits_next  = upd_grp.bits;
                        grp_cnt_next   = upd_grp.size;
                        grp_first_next = upd_grp.first;
                        grp_err_next   = upd_grp.err;
                        grp_done_next  = upd_grp.done;
                    end
                    if (!end_hit && run_cnt_reg == 7'd1 && !last_bit) begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                    end
                end
            end
            ST_END: begin
                // Send the partial group, then release the held one as last
                if (grp_cnt_reg != '0) begin
                    if (stat.can_push) begin
                        push          = 1'b1;
                        grp_bits_next = '0;
                        grp_cnt_next  = '0;
                        grp_err_next  = 1'b0;
                        grp_done_next = 1'b0;
                    end
                end else begin
                    close = stat.hold_valid;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            tree_pos_reg  <= '0;
            last_lit_reg  <= '0;
            pos_reg       <= '0;
            col_reg       <= '0;
            finished_reg  <= 1'b0;
            grp_bits_reg  <= '0;
            grp_cnt_reg   <= '0;
            grp_err_reg   <= 1'b0;
            grp_done_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tree_pos_reg  <= tree_pos_next;
            last_lit_reg  <= last_lit_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            finished_reg  <= finished_next;
            grp_bits_reg  <= grp_bits_next;
            grp_cnt_reg   <= grp_cnt_next;
            grp_err_reg   <= grp_err_next;
            grp_done_reg  <= grp_done_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        data_reg      <= data_next;
        bit_idx_reg   <= bit_idx_next;
        w_reg         <= w_next;
        total_reg     <= total_next;
        run_cnt_reg   <= run_cnt_next;
        run_err_reg   <= run_err_next;
        grp_first_reg <= grp_first_next;
    end

    trd_tree_mem u_tree (
        .aclk  (aclk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .re    (tree_re),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    trd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    trd_group_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .close    (close),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
